>>> hw/rtl/sbi_pkg.sv
// ----------------------------------------------------------------------------
// sbi_pkg
// Types and constants shared by the segment versus box intersection blocks.
// ----------------------------------------------------------------------------
package sbi_pkg;

    // Fraction bits of the entry parameter t
    localparam int PARAM_FRAC_BITS = 16;
    localparam int PARAM_W         = PARAM_FRAC_BITS + 1;
    // One restoring step per quotient bit
    localparam int DIV_STAGES      = PARAM_W;

    typedef logic signed [31:0] coord_t;
    typedef logic signed [32:0] delta_t;
    typedef logic        [32:0] mag_t;
    typedef logic [PARAM_W-1:0] param_t;
    typedef logic        [1:0]  axis_t;

    localparam axis_t AXIS_X = 2'd0;
    localparam axis_t AXIS_Y = 2'd1;
    localparam axis_t AXIS_Z = 2'd2;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_BOX_MIN_X = 3'd0;
    localparam logic [2:0] REG_BOX_MIN_Y = 3'd1;
    localparam logic [2:0] REG_BOX_MIN_Z = 3'd2;
    localparam logic [2:0] REG_BOX_MAX_X = 3'd3;
    localparam logic [2:0] REG_BOX_MAX_Y = 3'd4;
    localparam logic [2:0] REG_BOX_MAX_Z = 3'd5;

    localparam coord_t BOX_MIN_RESET = 32'sd0;
    localparam coord_t BOX_MAX_RESET = 32'sd65536;

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t start_z;
        coord_t end_x;
        coord_t end_y;
        coord_t end_z;
    } seg_t;

    typedef struct packed {
        logic   hit;
        param_t entry_param;
        axis_t  entry_axis;
        logic   start_inside;
    } result_t;

    typedef struct packed {
        coord_t [2:0] lo;
        coord_t [2:0] hi;
    } box_t;

    // Per-segment context carried alongside the dividers
    typedef struct packed {
        logic   [2:0] ent;
        logic         fail;
        coord_t [2:0] s;
        delta_t [2:0] dl;
    } side_t;

endpackage

>>> hw/rtl/sbi_regs.sv
// ----------------------------------------------------------------------------
// sbi_regs
// APB register file holding the box bounds.
// ----------------------------------------------------------------------------
module sbi_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output sbi_pkg::box_t box
);

    sbi_pkg::box_t box_reg;
    logic [2:0]    idx;
    logic          wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign box    = box_reg;

    // Write a bound on the access cycle of a write transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_reg.lo <= {3{sbi_pkg::BOX_MIN_RESET}};
            box_reg.hi <= {3{sbi_pkg::BOX_MAX_RESET}};
        end
        else if (wr_en)
        begin
            unique case (idx)
                sbi_pkg::REG_BOX_MIN_X: box_reg.lo[0] <= pwdata;
                sbi_pkg::REG_BOX_MIN_Y: box_reg.lo[1] <= pwdata;
                sbi_pkg::REG_BOX_MIN_Z: box_reg.lo[2] <= pwdata;
                sbi_pkg::REG_BOX_MAX_X: box_reg.hi[0] <= pwdata;
                sbi_pkg::REG_BOX_MAX_Y: box_reg.hi[1] <= pwdata;
                sbi_pkg::REG_BOX_MAX_Z: box_reg.hi[2] <= pwdata;
                default: ;
            endcase
        end
    end

    // Read back
    always_comb
    begin
        unique case (idx)
            sbi_pkg::REG_BOX_MIN_X: prdata = box_reg.lo[0];
            sbi_pkg::REG_BOX_MIN_Y: prdata = box_reg.lo[1];
            sbi_pkg::REG_BOX_MIN_Z: prdata = box_reg.lo[2];
            sbi_pkg::REG_BOX_MAX_X: prdata = box_reg.hi[0];
            sbi_pkg::REG_BOX_MAX_Y: prdata = box_reg.hi[1];
            sbi_pkg::REG_BOX_MAX_Z: prdata = box_reg.hi[2];
            default:                prdata = 32'd0;
        endcase
    end

endmodule

>>> hw/rtl/sbi_front.sv
// ----------------------------------------------------------------------------
// sbi_front
// Slab classification: difference vector, entering axes, reach check and
// divider operands for each axis.
// ----------------------------------------------------------------------------
module sbi_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  sbi_pkg::seg_t       seg,
    input  sbi_pkg::box_t       box,
    output logic                out_valid,
    output sbi_pkg::side_t      side,
    output sbi_pkg::mag_t [2:0] num,
    output sbi_pkg::mag_t [2:0] den
);

    logic                valid_reg;
    sbi_pkg::side_t      side_reg;
    sbi_pkg::side_t      side_next;
    sbi_pkg::mag_t [2:0] num_reg;
    sbi_pkg::mag_t [2:0] num_next;
    sbi_pkg::mag_t [2:0] den_reg;
    sbi_pkg::mag_t [2:0] den_next;
    logic          [2:0] fail_ax;
    sbi_pkg::coord_t [2:0] s_in;
    sbi_pkg::coord_t [2:0] e_in;

    assign s_in = {seg.start_z, seg.start_y, seg.start_x};
    assign e_in = {seg.end_z, seg.end_y, seg.end_x};

    // Classify each axis against its slab
    always_comb
    begin
        logic signed [32:0] s_ext;
        logic signed [32:0] dl;
        logic signed [32:0] d_lo;
        logic signed [32:0] d_hi;
        for (int i = 0; i < 3; i++)
        begin
            s_ext = {s_in[i][31], s_in[i]};
            dl    = $signed({e_in[i][31], e_in[i]}) - s_ext;
            d_lo  = $signed({box.lo[i][31], box.lo[i]}) - s_ext;
            d_hi  = $signed({box.hi[i][31], box.hi[i]}) - s_ext;
            side_next.s[i]  = s_in[i];
            side_next.dl[i] = dl;
            side_next.ent[i] = 1'b0;
            fail_ax[i]  = 1'b0;
            num_next[i] = '0;
            den_next[i] = '0;
            if ($signed(s_in[i]) < $signed(box.lo[i]))
            begin
                side_next.ent[i] = 1'b1;
                fail_ax[i]  = d_lo > dl;
                num_next[i] = d_lo;
                den_next[i] = dl;
            end
            else if ($signed(s_in[i]) > $signed(box.hi[i]))
            begin
                side_next.ent[i] = 1'b1;
                fail_ax[i]  = d_hi < dl;
                num_next[i] = -d_hi;
                den_next[i] = -dl;
            end
        end
        side_next.fail = |fail_ax;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload stage
    always_ff @(posedge clk)
    begin
        side_reg <= side_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
    end

    assign out_valid = valid_reg;
    assign side      = side_reg;
    assign num       = num_reg;
    assign den       = den_reg;

endmodule

>>> hw/rtl/sbi_divider.sv
// ----------------------------------------------------------------------------
// sbi_divider
// Pipelined restoring divider: floor(num * 2^PARAM_FRAC_BITS / den), one
// quotient bit per stage. Expects num <= den.
// ----------------------------------------------------------------------------
module sbi_divider (
    input  logic            clk,
    input  sbi_pkg::mag_t   num,
    input  sbi_pkg::mag_t   den,
    output sbi_pkg::param_t quot
);

    localparam int N = sbi_pkg::DIV_STAGES;
    localparam int PW = sbi_pkg::PARAM_W;

    logic [33:0]     rem_reg [N];
    sbi_pkg::mag_t   den_reg [N];
    sbi_pkg::param_t q_reg   [N];

    genvar k;
    generate
        for (k = 0; k < N; k++)
        begin : g_step
            logic [33:0]     r_in;
            sbi_pkg::mag_t   d_in;
            sbi_pkg::param_t q_in;
            logic            bit_q;

            if (k == 0)
            begin : g_first
                assign r_in = {1'b0, num};
                assign d_in = den;
                assign q_in = '0;
            end
            else
            begin : g_next
                assign r_in = {rem_reg[k-1][32:0], 1'b0};
                assign d_in = den_reg[k-1];
                assign q_in = q_reg[k-1];
            end

            assign bit_q = r_in >= {1'b0, d_in};

            // Compare, subtract and shift in one quotient bit
            always_ff @(posedge clk)
            begin
                rem_reg[k] <= bit_q ? (r_in - {1'b0, d_in}) : r_in;
                den_reg[k] <= d_in;
                q_reg[k]   <= {q_in[PW-2:0], bit_q};
            end
        end
    endgenerate

    assign quot = q_reg[N-1];

endmodule

>>> hw/rtl/sbi_resolve.sv
// ----------------------------------------------------------------------------
// sbi_resolve
// Pick the latest entry plane, project the other coordinates to it and check
// them against the box. Three register stages.
// ----------------------------------------------------------------------------
module sbi_resolve (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  sbi_pkg::side_t        side,
    input  sbi_pkg::param_t [2:0] quot,
    input  sbi_pkg::box_t         box,
    output logic                  done,
    output sbi_pkg::result_t      result
);

    localparam int P = sbi_pkg::PARAM_FRAC_BITS;

    // Stage A: entry selection
    logic             a_vld_reg;
    sbi_pkg::axis_t   a_which_reg;
    sbi_pkg::axis_t   a_which_next;
    sbi_pkg::param_t  a_t_reg;
    sbi_pkg::param_t  a_t_next;
    logic             a_pre_reg;
    logic             a_inside_reg;
    sbi_pkg::side_t   a_side_reg;

    // Stage B: products
    logic             b_vld_reg;
    sbi_pkg::axis_t   b_which_reg;
    sbi_pkg::param_t  b_t_reg;
    logic             b_pre_reg;
    logic             b_inside_reg;
    sbi_pkg::coord_t [2:0] b_s_reg;
    logic signed [50:0] b_prod_reg [3];

    // Stage C: output
    logic             done_reg;
    sbi_pkg::result_t result_reg;
    sbi_pkg::result_t result_next;

    // Take the largest t, lower axis on ties
    always_comb
    begin
        logic found;
        found        = 1'b0;
        a_which_next = sbi_pkg::AXIS_X;
        a_t_next     = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (side.ent[i] && (!found || quot[i] > a_t_next))
            begin
                found        = 1'b1;
                a_which_next = 2'(i);
                a_t_next     = quot[i];
            end
        end
    end

    // Project and bounds-check the coordinates at t
    always_comb
    begin
        logic signed [50:0] p;
        logic               chk;
        chk = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            p = (b_prod_reg[i] >>> P) + $signed({{19{b_s_reg[i][31]}}, b_s_reg[i]});
            if (2'(i) != b_which_reg)
            begin
                if (p < $signed({{19{box.lo[i][31]}}, box.lo[i]}) ||
                    p > $signed({{19{box.hi[i][31]}}, box.hi[i]}))
                begin
                    chk = 1'b0;
                end
            end
        end
        result_next.hit          = b_pre_reg & chk;
        result_next.entry_param  = (b_pre_reg & chk) ? b_t_reg : '0;
        result_next.entry_axis   = (b_pre_reg & chk) ? b_which_reg : sbi_pkg::AXIS_X;
        result_next.start_inside = b_inside_reg;
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            a_vld_reg <= in_valid;
            b_vld_reg <= a_vld_reg;
            done_reg  <= b_vld_reg;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        a_which_reg  <= a_which_next;
        a_t_reg      <= a_t_next;
        a_pre_reg    <= !side.fail && (side.ent != 3'b000);
        a_inside_reg <= !side.fail && (side.ent == 3'b000);
        a_side_reg   <= side;

        b_which_reg  <= a_which_reg;
        b_t_reg      <= a_t_reg;
        b_pre_reg    <= a_pre_reg;
        b_inside_reg <= a_inside_reg;
        b_s_reg      <= a_side_reg.s;
        for (int i = 0; i < 3; i++)
        begin
            b_prod_reg[i] <= $signed(a_side_reg.dl[i]) * $signed({1'b0, a_t_reg});
        end

        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> hw/rtl/segment_box_intersect.sv
// ----------------------------------------------------------------------------
// segment_box_intersect
// Segment versus axis-aligned box test (slab entry method), fully pipelined.
// ----------------------------------------------------------------------------
// Takes one segment per clock; busy is always low. Each result appears on
// result for one cycle with done high. The classification stage loads at the
// clock edge that accepts the segment. It is followed by one stage per bit
// of the 17-bit entry-parameter divider, then the selection, multiply and
// bounds-check stages.
// The receiver cannot stall. Write the box registers only while no segment
// is in flight.
module segment_box_intersect (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  logic             start,
    output logic             busy,
    input  sbi_pkg::seg_t    seg,
    output logic             done,
    output sbi_pkg::result_t result
);

    localparam int N = sbi_pkg::DIV_STAGES;

    sbi_pkg::box_t         box;
    logic                  f_valid;
    sbi_pkg::side_t        f_side;
    sbi_pkg::mag_t [2:0]   f_num;
    sbi_pkg::mag_t [2:0]   f_den;
    sbi_pkg::param_t [2:0] quot;
    logic [N-1:0]          vld_reg;
    sbi_pkg::side_t        side_reg [N];

    assign busy = 1'b0;

    sbi_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .box     (box)
    );

    sbi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start & ~busy),
        .seg       (seg),
        .box       (box),
        .out_valid (f_valid),
        .side      (f_side),
        .num       (f_num),
        .den       (f_den)
    );

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_div
            sbi_divider u_div (
                .clk  (clk),
                .num  (f_num[g]),
                .den  (f_den[g]),
                .quot (quot[g])
            );
        end
    endgenerate

    // Hold valid bits and context in step with the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[N-2:0], f_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg[0] <= f_side;
        for (int i = 1; i < N; i++)
        begin
            side_reg[i] <= side_reg[i-1];
        end
    end

    sbi_resolve u_resolve (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (vld_reg[N-1]),
        .side     (side_reg[N-1]),
        .quot     (quot),
        .box      (box),
        .done     (done),
        .result   (result)
    );

    // A hit never reports an inside start
    a_hit_not_inside: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.hit |-> !result.start_inside)
        else $error("hit with start_inside set");

    // A miss clears the entry fields
    a_miss_clear: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.hit |-> result.entry_param == '0 &&
                                result.entry_axis == sbi_pkg::AXIS_X)
        else $error("miss with entry fields set");

    // Entry parameter never exceeds one
    a_param_range: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.hit |->
            result.entry_param <= sbi_pkg::param_t'(1 << sbi_pkg::PARAM_FRAC_BITS))
        else $error("entry parameter above one");

endmodule
